// ----- design/slt_pkg.sv -----
// shared types and constants for the sorted list table
// opcode and status codes, controller/datapath command and status bundles
// no dependencies
package slt_pkg;

    // default configuration
    localparam int SLT_CAPACITY  = 16;
    localparam int SLT_KEY_WIDTH = 32;

    // fixed port widths
    localparam int OPCODE_W    = 3;
    localparam int KEY_IN_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT       = 3'd0,
        OP_DELETE       = 3'd1,
        OP_RETRIEVE     = 3'd2,
        OP_RESET_CURSOR = 3'd3,
        OP_GET_NEXT     = 3'd4,
        OP_MAKE_EMPTY   = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PAST_END  = 2'd3
    } t_status;

    // work pointer update
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_TOP,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    // memory read address select
    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_NEXT,
        RD_CURSOR
    } t_rd_sel;

    // memory write select
    typedef enum logic [2:0] {
        WR_NONE,
        WR_UP_DATA,
        WR_UP_KEY,
        WR_PTR_KEY,
        WR_PTR_DATA
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } t_cnt_op;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_CLEAR,
        CUR_INC
    } t_cur_op;

    // controller to datapath
    typedef struct packed {
        logic    load_key;
        t_ptr_op ptr_op;
        t_rd_sel rd_sel;
        t_wr_op  wr_op;
        t_cnt_op cnt_op;
        t_cur_op cur_op;
        logic    res_load;
        t_status res_status;
        logic    res_found;
        logic    res_key_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lt;
        logic eq;
        logic ptr_zero;
        logic ptr_last;
        logic empty;
        logic full;
        logic cur_ok;
        logic out_free;
    } t_sts;

endpackage

// ----- design/sorted_list_table.sv -----
// sorted list table, top level
// Keeps up to CAPACITY signed keys in ascending order in a one-read one-write key memory.
// Input channel: i_in_valid / o_in_stall with i_opcode and i_key; one item is taken
// per transfer and gives exactly one result on the output channel o_out_valid /
// i_out_stall (o_status, o_found, o_read_key, o_count, o_full_res).
// Steps from the input transfer to the load of the result register:
//   reset cursor, make empty, unused opcode, full insert, empty search: at dispatch; get next: a cursor read
//   insert: a read and compare per stored key not smaller than the new key, each moved up one slot
//   retrieve or absent delete: a read and compare per key scanned up to the match or the end
//   delete: the scan up to the match, then a read and a write per key moved down behind it
// The walk is set by the memory: one registered read and one write per cycle,
// a compare on each read word.
// A new item can be taken in the cycle after the previous result is loaded.
// Results wait in an output register; while the receiver stalls, the block may take
// and work on the next item but holds its result until the register frees.
// Reset (synchronous, active low) empties the table, zeroes the read cursor and
// drops any pending result; the memory itself is not cleared.
// Depends on slt_pkg, slt_ctrl and slt_dpath.
module sorted_list_table #(
    parameter int CAPACITY  = slt_pkg::SLT_CAPACITY,
    parameter int KEY_WIDTH = slt_pkg::SLT_KEY_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [slt_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic signed [slt_pkg::KEY_IN_W-1:0]  i_key,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [slt_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_found,
    output logic signed [slt_pkg::KEY_IN_W-1:0]  o_read_key,
    output logic [slt_pkg::COUNT_OUT_W-1:0]      o_count,
    output logic                                 o_full_res
);
    import slt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    slt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and compare
    slt_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_read_key  (o_read_key),
        .o_count     (o_count),
        .o_full_res  (o_full_res)
    );

endmodule

// ----- design/slt_ctrl.sv -----
// controller state machine for the sorted list table
// sequences memory walks and result transfers; uses slt_pkg
module slt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [slt_pkg::OPCODE_W-1:0]  i_opcode,
    output logic                          o_in_stall,
    input  slt_pkg::t_sts                 i_sts,
    output slt_pkg::t_cmd                 o_cmd
);
    import slt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_GET_OUT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_opcode r_op;
    t_opcode n_op;
    logic    in_accept;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '{
            load_key:    1'b0,
            ptr_op:      PTR_HOLD,
            rd_sel:      RD_PTR,
            wr_op:       WR_NONE,
            cnt_op:      CNT_HOLD,
            cur_op:      CUR_HOLD,
            res_load:    1'b0,
            res_status:  ST_OK,
            res_found:   1'b0,
            res_key_sel: 1'b0
        };
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_cmd.load_key = 1'b1;
                    n_op           = t_opcode'(i_opcode);
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_op)
                    OP_INSERT: begin
                        o_cmd.cur_op = CUR_CLEAR;
                        priority if (i_sts.full) begin
                            if (i_sts.out_free) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_FULL;
                                n_state          = S_IDLE;
                            end
                        end else if (i_sts.empty) begin
                            o_cmd.ptr_op = PTR_ZERO;
                            n_state      = S_INS_PUT;
                        end else begin
                            o_cmd.ptr_op = PTR_TOP;
                            n_state      = S_INS_RD;
                        end
                    end
                    OP_DELETE, OP_RETRIEVE: begin
                        if (r_op == OP_DELETE) begin
                            o_cmd.cur_op = CUR_CLEAR;
                        end
                        if (i_sts.empty) begin
                            if (i_sts.out_free) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = (r_op == OP_DELETE) ? ST_NOT_FOUND : ST_OK;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.ptr_op = PTR_ZERO;
                            n_state      = S_SRCH_RD;
                        end
                    end
                    OP_GET_NEXT: begin
                        if (i_sts.cur_ok) begin
                            o_cmd.rd_sel = RD_CURSOR;
                            n_state      = S_GET_OUT;
                        end else if (i_sts.out_free) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_PAST_END;
                            n_state          = S_IDLE;
                        end
                    end
                    OP_RESET_CURSOR: begin
                        if (i_sts.out_free) begin
                            o_cmd.cur_op   = CUR_CLEAR;
                            o_cmd.res_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    OP_MAKE_EMPTY: begin
                        if (i_sts.out_free) begin
                            o_cmd.cnt_op   = CNT_CLEAR;
                            o_cmd.res_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    default: begin
                        // unused opcodes change nothing
                        if (i_sts.out_free) begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                endcase
            end
            // insert walks down from the top, moving keys not smaller than the new key up one slot
            S_INS_RD: begin
                o_cmd.rd_sel = RD_PTR;
                n_state      = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (!i_sts.lt) begin
                    o_cmd.wr_op = WR_UP_DATA;
                    if (i_sts.ptr_zero) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_cmd.ptr_op = PTR_DEC;
                        n_state      = S_INS_RD;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.wr_op    = WR_UP_KEY;
                    o_cmd.cnt_op   = CNT_INC;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_INS_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_op    = WR_PTR_KEY;
                    o_cmd.cnt_op   = CNT_INC;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            // ascending search for the first equal key
            S_SRCH_RD: begin
                o_cmd.rd_sel = RD_PTR;
                n_state      = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                priority if (i_sts.eq) begin
                    if (r_op == OP_DELETE) begin
                        n_state = S_DEL_RD;
                    end else if (i_sts.out_free) begin
                        o_cmd.res_load  = 1'b1;
                        o_cmd.res_found = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_sts.ptr_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = (r_op == OP_DELETE) ? ST_NOT_FOUND : ST_OK;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = S_SRCH_RD;
                end
            end
            // delete closes the gap, moving later keys down one slot
            S_DEL_RD: begin
                if (i_sts.ptr_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.cnt_op   = CNT_DEC;
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_sel = RD_PTR_NEXT;
                    n_state      = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_op  = WR_PTR_DATA;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_DEL_RD;
            end
            S_GET_OUT: begin
                o_cmd.rd_sel = RD_CURSOR;
                if (i_sts.out_free) begin
                    o_cmd.cur_op      = CUR_INC;
                    o_cmd.res_load    = 1'b1;
                    o_cmd.res_key_sel = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_INSERT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // a result is only loaded when the output register can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    // every result ends the item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after result");

    // no insert into a full table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cnt_op == CNT_INC) |-> !i_sts.full)
        else $error("count incremented while full");

endmodule

// ----- design/slt_dpath.sv -----
// datapath for the sorted list table
// key memory, count, cursor, walk pointer, compare and output register; uses slt_pkg
module slt_dpath #(
    parameter int CAPACITY  = slt_pkg::SLT_CAPACITY,
    parameter int KEY_WIDTH = slt_pkg::SLT_KEY_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  slt_pkg::t_cmd                        i_cmd,
    output slt_pkg::t_sts                        o_sts,
    input  logic signed [slt_pkg::KEY_IN_W-1:0]  i_key,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [slt_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_found,
    output logic signed [slt_pkg::KEY_IN_W-1:0]  o_read_key,
    output logic [slt_pkg::COUNT_OUT_W-1:0]      o_count,
    output logic                                 o_full_res
);
    import slt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]        r_ptr;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_cursor;
    logic                 r_out_valid;
    t_status              r_status;
    logic                 r_found;
    logic [KEY_IN_W-1:0]  r_read_key;
    logic [COUNT_OUT_W-1:0] r_count_out;
    logic                 r_full_res;

    logic [CW-1:0]        n_count;
    logic [CW-1:0]        n_cursor;
    logic [AW-1:0]        n_ptr;

    logic [KEY_WIDTH+KEY_IN_W-1:0]    key_wide;
    logic [KEY_WIDTH+KEY_IN_W-1:0]    rd_wide;
    logic [CW+COUNT_OUT_W-1:0]        cnt_wide;
    logic [AW-1:0]        ptr_next;
    logic [CW-1:0]        ptr_p1;
    logic [CW-1:0]        count_m1;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 out_free;

    // key width conversion in both directions
    assign key_wide = {{KEY_WIDTH{1'b0}}, i_key};
    assign rd_wide  = {{KEY_IN_W{1'b0}}, r_rd_data};
    assign cnt_wide = {{COUNT_OUT_W{1'b0}}, n_count};

    assign ptr_next = r_ptr + 1'b1;
    assign ptr_p1   = CW'(r_ptr) + 1'b1;
    assign count_m1 = r_count - 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    // read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_PTR:      rd_addr = r_ptr;
            RD_PTR_NEXT: rd_addr = ptr_next;
            RD_CURSOR:   rd_addr = r_cursor[AW-1:0];
            default:     rd_addr = r_ptr;
        endcase
    end

    // write port select
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_ptr;
        wr_data = r_key;
        unique case (i_cmd.wr_op)
            WR_NONE:     wr_en = 1'b0;
            WR_UP_DATA: begin
                wr_addr = ptr_next;
                wr_data = r_rd_data;
            end
            WR_UP_KEY:   wr_addr = ptr_next;
            WR_PTR_KEY:  wr_addr = r_ptr;
            WR_PTR_DATA: wr_data = r_rd_data;
            default:     wr_en = 1'b0;
        endcase
    end

    // key memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // count, cursor and pointer next values
    always_comb begin
        unique case (i_cmd.cnt_op)
            CNT_HOLD:  n_count = r_count;
            CNT_INC:   n_count = r_count + 1'b1;
            CNT_DEC:   n_count = count_m1;
            CNT_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
        unique case (i_cmd.cur_op)
            CUR_HOLD:  n_cursor = r_cursor;
            CUR_CLEAR: n_cursor = '0;
            CUR_INC:   n_cursor = r_cursor + 1'b1;
            default:   n_cursor = r_cursor;
        endcase
        unique case (i_cmd.ptr_op)
            PTR_HOLD: n_ptr = r_ptr;
            PTR_ZERO: n_ptr = '0;
            PTR_TOP:  n_ptr = count_m1[AW-1:0];
            PTR_INC:  n_ptr = ptr_next;
            PTR_DEC:  n_ptr = r_ptr - 1'b1;
            default:  n_ptr = r_ptr;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working payload and result register
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load_key) begin
            r_key <= key_wide[KEY_WIDTH-1:0];
        end
        if (i_cmd.res_load) begin
            r_status    <= i_cmd.res_status;
            r_found     <= i_cmd.res_found;
            r_read_key  <= i_cmd.res_key_sel ? rd_wide[KEY_IN_W-1:0] : '0;
            r_count_out <= cnt_wide[COUNT_OUT_W-1:0];
            r_full_res  <= (n_count == CW'(CAPACITY));
        end
    end

    // status back to the controller
    assign o_sts = '{
        lt:       ($signed(r_rd_data) < $signed(r_key)),
        eq:       (r_rd_data == r_key),
        ptr_zero: (r_ptr == '0),
        ptr_last: (ptr_p1 == r_count),
        empty:    (r_count == '0),
        full:     (r_count == CW'(CAPACITY)),
        cur_ok:   (r_cursor < r_count),
        out_free: out_free
    };

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_read_key  = r_read_key;
    assign o_count     = r_count_out;
    assign o_full_res  = r_full_res;

    // count stays within capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a loaded result is offered next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |=> r_out_valid)
        else $error("loaded result not offered");

    // cursor reads only touch stored entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_sel == RD_CURSOR) |-> (r_cursor < r_count))
        else $error("cursor read beyond stored keys");

endmodule
